FILE: design/brb_pkg.sv
package brb_pkg;

  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int LEN_W  = PTR_W + 1;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 10;
  localparam int CMD_W  = 2;
  localparam int CUSH_W = 10;
  localparam int WIDE_W = (LEN_W > CUSH_W) ? LEN_W + 1 : CUSH_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  localparam int REG_CUSHION = 0;

  typedef struct packed {
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_after_cushion;
    logic             near_full;
    logic             is_empty;
    logic [CNT_W-1:0] contiguous_free;
    logic             access_error;
    logic             take_read;
  } status_t;

endpackage

FILE: design/brb_in_if.sv
interface brb_in_if;
  logic                          valid;
  logic                          ready;
  logic [brb_pkg::CMD_W-1:0]     cmd;
  logic [brb_pkg::DATA_W-1:0]    write_byte;

  modport source (output valid, output cmd, output write_byte, input ready);
  modport sink (input valid, input cmd, input write_byte, output ready);
endinterface

FILE: design/brb_out_if.sv
interface brb_out_if;
  logic                          valid;
  logic                          ready;
  logic [brb_pkg::DATA_W-1:0]    read_byte;
  logic [brb_pkg::CNT_W-1:0]     used_count;
  logic [brb_pkg::CNT_W-1:0]     free_after_cushion;
  logic                          near_full;
  logic                          is_empty;
  logic [brb_pkg::CNT_W-1:0]     contiguous_free;
  logic                          access_error;

  modport source (
    output valid, output read_byte, output used_count, output free_after_cushion,
    output near_full, output is_empty, output contiguous_free, output access_error,
    input ready
  );
  modport sink (
    input valid, input read_byte, input used_count, input free_after_cushion,
    input near_full, input is_empty, input contiguous_free, input access_error,
    output ready
  );
endinterface

FILE: design/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/byte_ring_buffer_with_cushion_unit.sv
// A result passes the registered byte store read and status register, then the
// output register. Throughput: one command beat per cycle unless a stalled
// output holds req.ready low; the pointers are updated in the accept cycle, so
// back-to-back commands see each other's effects.
// Reset (synchronous, active high) clears both pointers, the cushion register and
// all valid flags; the byte store itself is not cleared.
module byte_ring_buffer_with_cushion_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [brb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [brb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  brb_in_if.sink                            req,
  brb_out_if.source                         rsp
);

  localparam int PTR_W  = brb_pkg::PTR_W;
  localparam int LEN_W  = brb_pkg::LEN_W;
  localparam int WIDE_W = brb_pkg::WIDE_W;
  localparam int CNT_W  = brb_pkg::CNT_W;

  logic [PTR_W-1:0]           rp, wp, rp_next, wp_next;
  logic [brb_pkg::CUSH_W-1:0] cushion;

  logic                       accept;
  logic                       mem_we, mem_re;
  logic                       err, take;
  logic [brb_pkg::DATA_W-1:0] mem_rdata;

  logic [LEN_W-1:0]           held_cur, used, free;
  logic [WIDE_W-1:0]          free_w, cush_w;
  logic [LEN_W-1:0]           contig;

  logic                       s1_valid, s1_move;
  brb_pkg::status_t           s1, stat;

  function automatic logic [LEN_W-1:0] held_of(input logic [PTR_W-1:0] r,
                                               input logic [PTR_W-1:0] w);
    if (w >= r) begin
      return LEN_W'(w) - LEN_W'(r);
    end
    return LEN_W'(brb_pkg::DEPTH) - (LEN_W'(r) - LEN_W'(w));
  endfunction

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(brb_pkg::DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Configuration port; only one register, so every address decodes to it.
  assign pready = 1'b1;
  assign prdata = brb_pkg::APB_DATA_W'(cushion);

  always_ff @(posedge clk) begin
    if (rst) begin
      cushion <= '0;
    end else if (psel && penable && pwrite) begin
      cushion <= pwdata[brb_pkg::CUSH_W-1:0];
    end
  end

  assign s1_move   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;
  assign held_cur  = held_of(rp, wp);

  always_comb begin
    rp_next = rp;
    wp_next = wp;
    mem_we  = 1'b0;
    err     = 1'b0;
    take    = 1'b0;
    if (accept) begin
      unique case (req.cmd)
        brb_pkg::CMD_WRITE: begin
          if (held_cur >= LEN_W'(brb_pkg::DEPTH - 1)) begin
            err = 1'b1;
          end else begin
            mem_we  = 1'b1;
            wp_next = next_pos(wp);
          end
        end
        brb_pkg::CMD_READ: begin
          if (rp == wp) begin
            err = 1'b1;
          end else begin
            take    = 1'b1;
            rp_next = next_pos(rp);
          end
        end
        brb_pkg::CMD_QUERY: begin
          // An empty buffer is realigned to the start of the store.
          if (rp == wp) begin
            rp_next = '0;
            wp_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_re = take;

  brb_ram #(
    .WIDTH(brb_pkg::DATA_W),
    .DEPTH(brb_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wp),
    .wdata(req.write_byte),
    .re   (mem_re),
    .raddr(rp),
    .rdata(mem_rdata)
  );

  // Status is taken from the pointers as they stand after this command.
  always_comb begin
    used   = held_of(rp_next, wp_next);
    free   = LEN_W'(brb_pkg::DEPTH - 1) - used;
    free_w = WIDE_W'(free);
    cush_w = WIDE_W'(cushion);
    if (rp_next == wp_next) begin
      contig = LEN_W'(brb_pkg::DEPTH / 2);
    end else if (rp_next > wp_next) begin
      contig = LEN_W'(rp_next) - LEN_W'(wp_next) - LEN_W'(1);
    end else if (rp_next != '0) begin
      contig = LEN_W'(brb_pkg::DEPTH) - LEN_W'(wp_next);
    end else begin
      contig = LEN_W'(brb_pkg::DEPTH - 1) - LEN_W'(wp_next);
    end
    stat.used_count         = CNT_W'(used);
    stat.free_after_cushion = (free_w > cush_w) ? CNT_W'(free_w - cush_w) : '0;
    stat.near_full          = (free_w < cush_w);
    stat.is_empty           = (rp_next == wp_next);
    stat.contiguous_free    = CNT_W'(contig);
    stat.access_error       = err;
    stat.take_read          = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      wp        <= '0;
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      rp <= rp_next;
      wp <= wp_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stat;
    end
    if (s1_move) begin
      rsp.read_byte          <= s1.take_read ? mem_rdata : '0;
      rsp.used_count         <= s1.used_count;
      rsp.free_after_cushion <= s1.free_after_cushion;
      rsp.near_full          <= s1.near_full;
      rsp.is_empty           <= s1.is_empty;
      rsp.contiguous_free    <= s1.contiguous_free;
      rsp.access_error       <= s1.access_error;
    end
  end

endmodule
